// File: hdl/mexp_pkg.sv
package mexp_pkg;

    // Default operand width for the exponentiation datapath
    localparam int WIDTH_DEFAULT = 32;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_MUL    = 5'b00100,
        S_SQR    = 5'b01000,
        S_DONE   = 5'b10000
    } mexp_state_t;

endpackage

// File: hdl/modular_exponentiation_unit.sv
// Operation: a request takes L + P products of the shared multiplier, L = bit length of the
//   exponent (1 for a zero exponent), P = number of ones in it. A zero modulus goes from
//   the input transaction straight to the result, with no product.
// Throughput: one item at a time; the next transaction is taken the cycle after the result
//   loads the free output register.
// Reset (rst_n, asynchronous, active low): modulus is 1, no item in flight, no result.
module modular_exponentiation_unit #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [WIDTH-1:0] cfg_write_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] power_mod,
    output logic             bad_modulus
);

    mexp_pkg::mexp_state_t state_reg, state_next;

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic             bad_reg, bad_next;
    logic             out_valid_reg;
    logic [WIDTH-1:0] power_mod_reg;
    logic             bad_modulus_reg;

    logic             in_accept;
    logic             out_load;
    logic             mod_zero;
    logic [WIDTH-1:0] one_mod;
    logic [WIDTH-1:0] exp_shift;

    logic             mul_start;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic             mul_busy;
    logic             mul_done;
    logic [WIDTH-1:0] mul_result;

    assign mod_zero  = (modulus_reg == '0);
    assign one_mod   = (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign in_stall  = (state_reg != mexp_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == mexp_pkg::S_DONE) && (!out_valid_reg || !out_stall);
    assign exp_shift = {1'b0, exp_reg[WIDTH-1:1]};

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (modulus_reg),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_result)
    );

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        b_next     = b_reg;
        exp_next   = exp_reg;
        bad_next   = bad_reg;
        mul_start  = 1'b0;
        mul_a      = acc_reg;
        mul_b      = b_reg;
        case (state_reg)
            mexp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    exp_next = exponent;
                    bad_next = mod_zero;
                    if (mod_zero)
                    begin
                        acc_next   = '0;
                        state_next = mexp_pkg::S_DONE;
                    end
                    else
                    begin
                        // Reduce the base: (1 mod m) * base, mod m
                        acc_next   = one_mod;
                        mul_start  = 1'b1;
                        mul_a      = one_mod;
                        mul_b      = base_value;
                        state_next = mexp_pkg::S_REDUCE;
                    end
                end
            end
            mexp_pkg::S_REDUCE:
            begin
                if (mul_done)
                begin
                    b_next = mul_result;
                    if (exp_reg == '0)
                    begin
                        state_next = mexp_pkg::S_DONE;
                    end
                    else if (exp_reg[0])
                    begin
                        mul_start  = 1'b1;
                        mul_a      = acc_reg;
                        mul_b      = mul_result;
                        state_next = mexp_pkg::S_MUL;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = mul_result;
                        mul_b      = mul_result;
                        state_next = mexp_pkg::S_SQR;
                    end
                end
            end
            mexp_pkg::S_MUL:
            begin
                if (mul_done)
                begin
                    acc_next = mul_result;
                    // Square only if higher exponent bits remain
                    if (exp_shift == '0)
                    begin
                        state_next = mexp_pkg::S_DONE;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = b_reg;
                        mul_b      = b_reg;
                        state_next = mexp_pkg::S_SQR;
                    end
                end
            end
            mexp_pkg::S_SQR:
            begin
                if (mul_done)
                begin
                    b_next   = mul_result;
                    exp_next = exp_shift;
                    if (exp_shift == '0)
                    begin
                        state_next = mexp_pkg::S_DONE;
                    end
                    else if (exp_shift[0])
                    begin
                        mul_start  = 1'b1;
                        mul_a      = acc_reg;
                        mul_b      = mul_result;
                        state_next = mexp_pkg::S_MUL;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = mul_result;
                        mul_b      = mul_result;
                        state_next = mexp_pkg::S_SQR;
                    end
                end
            end
            mexp_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = mexp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::S_IDLE;
            modulus_reg   <= WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                modulus_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
        exp_reg <= exp_next;
        bad_reg <= bad_next;
        if (out_load)
        begin
            power_mod_reg   <= acc_reg;
            bad_modulus_reg <= bad_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign power_mod   = power_mod_reg;
    assign bad_modulus = bad_modulus_reg;

`ifndef SYNTHESIS
    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_modulus_reg) |-> (power_mod_reg == '0))
        else $error("error result is not zero");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bad_modulus_reg) |-> (power_mod_reg < modulus_reg))
        else $error("result not below modulus");

    a_zero_mod_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mod_zero) |=> (state_reg == mexp_pkg::S_DONE))
        else $error("zero modulus did not finish at once");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");
`endif

endmodule

// File: hdl/mexp_mulmod.sv
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   m_ext;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH-1:0] step1;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_red;

    // One interleaved step: acc = 2*acc (+ a if the multiplier bit is set), mod m
    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        step1   = dbl_red[WIDTH-1:0];
        sum     = {1'b0, step1} + {1'b0, a_reg};
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
        acc_next = b_reg[WIDTH-1] ? sum_red[WIDTH-1:0] : step1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a preceding busy cycle");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && m_reg != '0) |-> (acc_reg < m_reg))
        else $error("multiplier result not reduced");
`endif

endmodule

// File: bench/tb_modular_exponentiation_unit.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;

    localparam int W = mexp_pkg::WIDTH_DEFAULT;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 30;
    localparam logic [W-1:0] ALL_ONES = '1;
    localparam logic [W-1:0] TOP_PRIME = 32'd4294967291;

    typedef struct packed {
        logic [W-1:0] power;
        logic         bad;
    } power_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_write_en = 1'b0;
    logic [W-1:0] cfg_write_data = '0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [W-1:0] base_value = '0;
    logic [W-1:0] exponent = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] power_mod;
    logic         bad_modulus;

    power_result_t expected_powers[$];
    logic [W-1:0]  modulus_shadow = W'(1);

    bit          in_idle_on = 1'b0;
    bit          stall_on = 1'b0;
    int unsigned stall_run = 0;
    int unsigned idle_cycles = 0;

    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned bad_modulus_seen = 0;
    int unsigned modulus_writes = 0;

    modular_exponentiation_unit #(
        .WIDTH(W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .base_value(base_value),
        .exponent(exponent),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .power_mod(power_mod),
        .bad_modulus(bad_modulus)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Right-to-left square-and-multiply with double-width products.
    function automatic power_result_t predict_power(logic [W-1:0] b, logic [W-1:0] e,
                                                    logic [W-1:0] m);
        logic [2*W-1:0] acc;
        logic [2*W-1:0] sq;
        logic [2*W-1:0] mm;
        power_result_t  r;
        r.power = '0;
        r.bad = 1'b0;
        if (m == '0)
        begin
            r.bad = 1'b1;
            return r;
        end
        mm = {{W{1'b0}}, m};
        acc = 1 % mm;
        sq = {{W{1'b0}}, b} % mm;
        for (int i = 0; i < W; i++)
        begin
            if (e[i])
                acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        r.power = acc[W-1:0];
        return r;
    endfunction

    // Mostly short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(3);
        if (roll < 95)
            return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic [W-1:0] rand_of_length(int unsigned len);
        logic [W-1:0] v;
        v = $urandom;
        if (len == 0)
            return '0;
        if (len < W)
            v = v & ((W'(1) << len) - 1);
        v[len-1] = 1'b1;
        return v;
    endfunction

    task automatic send_power_request(input logic [W-1:0] b, input logic [W-1:0] e);
        int unsigned gap;
        gap = in_idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base_value <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_stall);
        expected_powers.push_back(predict_power(b, e, modulus_shadow));
        items_sent++;
    endtask

    // Drop valid and wait until every result is back and the unit is quiet.
    task automatic settle_unit();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_powers.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [W-1:0] value);
        settle_unit();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        modulus_shadow = value;
        modulus_writes++;
    endtask

    task automatic test_reset_modulus();
        // modulus is 1 out of reset: every power is 0
        send_power_request('0, '0);
        send_power_request(ALL_ONES, ALL_ONES);
        send_power_request(32'd5, '0);
    endtask

    task automatic test_zero_modulus();
        write_modulus('0);
        send_power_request(32'd3, 32'd5);
        send_power_request('0, '0);
        send_power_request(ALL_ONES, ALL_ONES);
    endtask

    task automatic test_max_modulus();
        write_modulus(ALL_ONES);
        send_power_request(ALL_ONES, 32'd1);
        send_power_request(ALL_ONES - 1, ALL_ONES);
        send_power_request('0, '0);
        send_power_request(32'd2, 32'd31);
        send_power_request(ALL_ONES, '0);
        send_power_request(32'd123456789, ALL_ONES);
    endtask

    task automatic test_small_modulus();
        write_modulus(32'd2);
        send_power_request(32'd7, '0);
        send_power_request(ALL_ONES, ALL_ONES);
        write_modulus(32'd3);
        send_power_request(ALL_ONES, 32'd3);
    endtask

    task automatic test_prime_modulus();
        write_modulus(TOP_PRIME);
        // Fermat: a^(p-1) = 1 mod p
        send_power_request(32'h9E3779B9, TOP_PRIME - 1);
        send_power_request('0, 32'd5);
        send_power_request('0, '0);
        send_power_request(TOP_PRIME, 32'd7);
    endtask

    task automatic test_random_traffic();
        logic [W-1:0] m;
        logic [W-1:0] b;
        logic [W-1:0] e;
        int unsigned  roll;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                1: m = '0;
                2: m = 32'd1;
                3: m = ALL_ONES;
                4: m = rand_of_length(8);
                5: m = rand_of_length(16) | 32'd1;
                6: m = 32'd2;
                8: m = TOP_PRIME;
                default: m = $urandom;
            endcase
            write_modulus(m);
            in_idle_on = (p % 4) == 1 || (p % 4) == 3;
            stall_on = (p % 4) >= 2;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                    b = '0;
                else if (roll < 10)
                    b = ALL_ONES;
                else if (roll < 15)
                    b = 32'd1;
                else
                    b = $urandom;
                roll = $urandom_range(99);
                if (roll < 5)
                    e = '0;
                else if (roll < 8)
                    e = ALL_ONES;
                else if (roll < 18)
                    e = $urandom;
                else
                    e = rand_of_length($urandom_range(W, 1));
                send_power_request(b, e);
            end
        end
        in_idle_on = 1'b0;
        stall_on = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_zero_modulus();
        test_max_modulus();
        test_small_modulus();
        test_prime_modulus();
        test_random_traffic();
        settle_unit();
        repeat (40) @(posedge clk);
        $display("Sent %0d requests, checked %0d powers (%0d with bad modulus flagged)",
                 items_sent, results_checked, bad_modulus_seen);
        $display("Used %0d modulus settings, %0d mismatches", modulus_writes, mismatch_count);
        if (mismatch_count == 0 && expected_powers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Output stall: alternate stalled and open runs while enabled.
    always @(posedge clk)
    begin
        if (stall_run != 0)
            stall_run <= stall_run - 1;
        else
        begin
            out_stall <= stall_on && !out_stall;
            stall_run <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        power_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (bad_modulus)
                bad_modulus_seen++;
            if (expected_powers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result power_mod=%h bad_modulus=%b",
                             $realtime, power_mod, bad_modulus);
            end
            else
            begin
                want = expected_powers.pop_front();
                if (power_mod !== want.power || bad_modulus !== want.bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: power_mod exp %h got %h, bad_modulus exp %b got %b",
                                 $realtime, want.power, power_mod, want.bad, bad_modulus);
                end
            end
        end
    end

    // Count cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
